/* hw/rtl/mbm_pkg.sv */
`default_nettype none

package mbm_pkg;

  localparam int unsigned HOLD_REGS = 8;
  localparam int unsigned FRAME_MAX = 256;

  localparam int unsigned REG_IDX_W = (HOLD_REGS > 1) ? $clog2(HOLD_REGS) : 1;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_CODE = 8'h03;

  localparam logic [7:0] REQ_COUNT_HI = 8'((HOLD_REGS >> 8) & 255);
  localparam logic [7:0] REQ_COUNT_LO = 8'(HOLD_REGS & 255);

  localparam logic [8:0] FRAME_LIMIT = 9'(FRAME_MAX);
  localparam logic [8:0] MIN_LEN     = 9'(5 + 2 * HOLD_REGS);
  localparam logic [8:0] DATA_START  = 9'd3;
  localparam logic [8:0] DATA_END    = 9'(3 + 2 * HOLD_REGS);

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_IDLE    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic [1:0] OUT_TX     = 2'd0;
  localparam logic [1:0] OUT_REG    = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd4;
  localparam logic [2:0] ST_CRC_ERROR = 3'd5;

  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/mbm_crc_serial.sv */
`default_nettype none

module mbm_crc_serial
  import mbm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire crc_cmd_t cmd_i,
  output logic          busy_o,
  output logic [15:0]   crc_o
);

  logic [15:0] crc_q;
  logic [7:0]  sh_q;
  logic [2:0]  cnt_q;
  logic        busy_q;
  logic        fb;
  logic [15:0] crc_d;

  // one bit per cycle, lsb first
  assign fb    = crc_q[0] ^ sh_q[0];
  assign crc_d = {1'b0, crc_q[15:1]} ^ (fb ? CRC_POLY : 16'h0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      sh_q   <= 8'h00;
      cnt_q  <= 3'd0;
      busy_q <= 1'b0;
    end else if (cmd_i.init) begin
      crc_q  <= CRC_INIT;
      busy_q <= 1'b0;
    end else if (cmd_i.feed) begin
      sh_q   <= cmd_i.data;
      cnt_q  <= 3'd0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      crc_q <= crc_d;
      sh_q  <= {1'b0, sh_q[7:1]};
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

`default_nettype wire

/* hw/rtl/mbm_reg_store.sv */
`default_nettype none

module mbm_reg_store
  import mbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [REG_IDX_W-1:0] waddr_i,
  input  wire logic [15:0]          wdata_i,
  input  wire logic [REG_IDX_W-1:0] raddr_i,
  output logic [15:0]               rdata_o
);

  logic [15:0] mem_q [HOLD_REGS];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/modbus_fc03_master_frame_engine.sv */
// Modbus RTU read-holding-registers master frame engine.
// Input channel (in_valid_i/in_ready_o) takes one item per transaction: start poll
// with a slave address, received byte, line idle, or response timeout.
// Output channel (out_valid_o/out_ready_i) returns result items from a single
// output register; last_o marks the final item caused by an input item.
// Config channel (cfg_valid_i/cfg_ready_o) writes start_register; it is always ready
// and should only be used while the block is idle.
// CRC-16 is computed by one bit-serial unit, one bit per cycle, so every byte
// fed to it keeps it busy until all its bits are shifted. A start item emits 8
// request bytes, the first six fed to the crc unit; each waits for the unit to be
// idle, and the next item is accepted after the last request byte is loaded.
// A received byte that feeds the crc holds off the next item until the unit is idle;
// others that emit nothing do not. Line idle and timeout items emit their results
// one per cycle from the cycle after acceptance while the receiver takes them.
// A stalled receiver holds the output register and the sequencer waits; the next
// input is accepted once the last result of the current item is loaded.
// After reset the block is idle and not receiving, counters are zero, the crc
// is 0xFFFF and start_register is zero.
`default_nettype none

module modbus_fc03_master_frame_engine
  import mbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  slave_addr_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic [5:0]       reg_index_o,
  output logic [15:0]      reg_value_o,
  output logic [2:0]       status_code_o,
  output logic [31:0]      good_count_o,
  output logic [31:0]      error_count_o,
  output logic             last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TX,
    S_REGS,
    S_STATUS
  } state_e;

  state_e               state_q;
  logic [15:0]          start_reg_q;
  logic                 phase_q;
  logic [7:0]           exp_addr_q;
  logic [8:0]           byte_count_q;
  logic [15:0]          tail_q;
  logic [1:0]           flags_q;
  logic [7:0]           hold_q;
  logic [31:0]          ok_cnt_q;
  logic [31:0]          fail_cnt_q;
  logic [2:0]           tx_idx_q;
  logic [REG_IDX_W-1:0] ridx_q;
  logic [2:0]           code_q;

  logic                 out_valid_q;
  logic [1:0]           out_kind_q;
  logic [7:0]           tx_byte_q;
  logic [5:0]           reg_index_q;
  logic [15:0]          reg_value_q;
  logic [2:0]           status_q;
  logic [31:0]          good_q;
  logic [31:0]          err_q;
  logic                 last_q;

  crc_cmd_t             crc_cmd;
  logic                 crc_busy;
  logic [15:0]          crc_val;
  logic                 accept_in;
  logic                 out_free;
  logic                 byte_take;
  logic                 in_data;
  logic [8:0]           off;
  logic [7:0]           req_byte;
  logic [2:0]           check_code;
  logic                 store_we;
  logic [REG_IDX_W-1:0] store_raddr;
  logic [15:0]          store_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !crc_busy;
  assign accept_in   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign byte_take = accept_in && (kind_i == KIND_BYTE) && phase_q &&
                     (byte_count_q < FRAME_LIMIT);
  assign in_data   = (byte_count_q >= DATA_START) && (byte_count_q < DATA_END);
  assign off       = byte_count_q - DATA_START;
  assign store_we  = byte_take && in_data && off[0];

  // registered read runs one entry ahead while the registers are sent
  always_comb begin
    store_raddr = '0;
    if (state_q == S_REGS) begin
      store_raddr = out_free ? (ridx_q + REG_IDX_W'(1)) : ridx_q;
    end
  end

  always_comb begin
    unique case (tx_idx_q)
      3'd0:    req_byte = exp_addr_q;
      3'd1:    req_byte = FUNC_CODE;
      3'd2:    req_byte = start_reg_q[15:8];
      3'd3:    req_byte = start_reg_q[7:0];
      3'd4:    req_byte = REQ_COUNT_HI;
      3'd5:    req_byte = REQ_COUNT_LO;
      3'd6:    req_byte = crc_val[7:0];
      default: req_byte = crc_val[15:8];
    endcase
  end

  always_comb begin
    if (byte_count_q < MIN_LEN) begin
      check_code = ST_SHORT;
    end else if (!flags_q[0]) begin
      check_code = ST_BAD_ADDR;
    end else if (!flags_q[1]) begin
      check_code = ST_BAD_FUNC;
    end else if (crc_val != tail_q) begin
      check_code = ST_CRC_ERROR;
    end else begin
      check_code = ST_OK;
    end
  end

  always_comb begin
    crc_cmd = '0;
    if (accept_in && (kind_i == KIND_START)) begin
      crc_cmd.init = 1'b1;
    end
    if (byte_take && (byte_count_q >= 9'd2)) begin
      crc_cmd.feed = 1'b1;
      crc_cmd.data = tail_q[7:0];
    end
    if ((state_q == S_TX) && out_free && !crc_busy) begin
      if (tx_idx_q < 3'd6) begin
        crc_cmd.feed = 1'b1;
        crc_cmd.data = req_byte;
      end
      if (tx_idx_q == 3'd7) begin
        crc_cmd.init = 1'b1;
      end
    end
  end

  mbm_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  mbm_reg_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (off[REG_IDX_W:1]),
    .wdata_i ({hold_q, rx_byte_i}),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_reg_q  <= 16'h0000;
      phase_q      <= 1'b0;
      exp_addr_q   <= 8'h00;
      byte_count_q <= 9'd0;
      tail_q       <= 16'h0000;
      flags_q      <= 2'b00;
      hold_q       <= 8'h00;
      ok_cnt_q     <= 32'd0;
      fail_cnt_q   <= 32'd0;
      tx_idx_q     <= 3'd0;
      ridx_q       <= '0;
      code_q       <= ST_OK;
      out_valid_q  <= 1'b0;
      out_kind_q   <= OUT_TX;
      tx_byte_q    <= 8'h00;
      reg_index_q  <= 6'd0;
      reg_value_q  <= 16'h0000;
      status_q     <= ST_OK;
      good_q       <= 32'd0;
      err_q        <= 32'd0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        start_reg_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            if (kind_i == KIND_START) begin
              phase_q      <= 1'b1;
              exp_addr_q   <= slave_addr_i;
              byte_count_q <= 9'd0;
              tail_q       <= 16'h0000;
              flags_q      <= 2'b00;
              hold_q       <= 8'h00;
              tx_idx_q     <= 3'd0;
              state_q      <= S_TX;
            end else if (phase_q) begin
              if (kind_i == KIND_BYTE) begin
                if (byte_take) begin
                  tail_q       <= {rx_byte_i, tail_q[15:8]};
                  byte_count_q <= byte_count_q + 9'd1;
                  if ((byte_count_q == 9'd0) && (rx_byte_i == exp_addr_q)) begin
                    flags_q[0] <= 1'b1;
                  end
                  if ((byte_count_q == 9'd1) && (rx_byte_i == FUNC_CODE)) begin
                    flags_q[1] <= 1'b1;
                  end
                  if (in_data && !off[0]) begin
                    hold_q <= rx_byte_i;
                  end
                end
              end else if (kind_i == KIND_TIMEOUT) begin
                phase_q    <= 1'b0;
                fail_cnt_q <= fail_cnt_q + 32'd1;
                code_q     <= ST_TIMEOUT;
                state_q    <= S_STATUS;
              end else begin
                phase_q <= 1'b0;
                code_q  <= check_code;
                if (check_code == ST_OK) begin
                  ok_cnt_q <= ok_cnt_q + 32'd1;
                  ridx_q   <= '0;
                  state_q  <= S_REGS;
                end else begin
                  fail_cnt_q <= fail_cnt_q + 32'd1;
                  state_q    <= S_STATUS;
                end
              end
            end
          end
        end
        S_TX: begin
          if (out_free && !crc_busy) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= OUT_TX;
            tx_byte_q   <= req_byte;
            reg_index_q <= 6'd0;
            reg_value_q <= 16'h0000;
            status_q    <= ST_OK;
            good_q      <= 32'd0;
            err_q       <= 32'd0;
            last_q      <= (tx_idx_q == 3'd7);
            tx_idx_q    <= tx_idx_q + 3'd1;
            if (tx_idx_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_REGS: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= OUT_REG;
            tx_byte_q   <= 8'h00;
            reg_index_q <= 6'(ridx_q);
            reg_value_q <= store_rdata;
            status_q    <= ST_OK;
            good_q      <= 32'd0;
            err_q       <= 32'd0;
            last_q      <= 1'b0;
            ridx_q      <= ridx_q + REG_IDX_W'(1);
            if (ridx_q == REG_IDX_W'(HOLD_REGS - 1)) begin
              state_q <= S_STATUS;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= OUT_STATUS;
            tx_byte_q   <= 8'h00;
            reg_index_q <= 6'd0;
            reg_value_q <= 16'h0000;
            status_q    <= code_q;
            good_q      <= ok_cnt_q;
            err_q       <= fail_cnt_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign tx_byte_o     = tx_byte_q;
  assign reg_index_o   = reg_index_q;
  assign reg_value_o   = reg_value_q;
  assign status_code_o = status_q;
  assign good_count_o  = good_q;
  assign error_count_o = err_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench
  import mbm_pkg::*;
();

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [5:0]  idx;
    logic [15:0] value;
    logic [2:0]  status;
    logic [31:0] good;
    logic [31:0] errs;
    logic        last;
  } master_out_t;

  typedef enum logic [3:0] {
    PM_GOOD,
    PM_EXTRA,
    PM_BAD_ADDR,
    PM_BAD_FUNC,
    PM_BAD_CRC,
    PM_SHORT,
    PM_TIMEOUT,
    PM_RESTART
  } poll_mode_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'h0000;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_BYTE;
  logic [7:0]  slave_addr_i = 8'h00;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  tx_byte_o;
  logic [5:0]  reg_index_o;
  logic [15:0] reg_value_o;
  logic [2:0]  status_code_o;
  logic [31:0] good_count_o;
  logic [31:0] error_count_o;
  logic        last_o;

  // predicted state of the master
  logic [15:0] start_reg_m;
  logic        rx_active;
  logic [7:0]  poll_addr;
  logic [8:0]  rx_count;
  logic [15:0] rx_crc;
  logic [15:0] rx_tail;
  logic        addr_ok;
  logic        func_ok;
  logic [7:0]  hi_hold;
  logic [15:0] reg_img [HOLD_REGS];
  logic [31:0] good_total;
  logic [31:0] fail_total;

  master_out_t master_out_q [$];
  int unsigned mismatches = 0;
  int unsigned items_fed = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  modbus_fc03_master_frame_engine i_dut (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic master_out_t out_item(logic [1:0] k, logic [7:0] tx, logic [5:0] idx,
                                           logic [15:0] val, logic [2:0] st,
                                           logic [31:0] good, logic [31:0] errs,
                                           logic last);
    master_out_t r;
    r.kind   = k;
    r.tx     = tx;
    r.idx    = idx;
    r.value  = val;
    r.status = st;
    r.good   = good;
    r.errs   = errs;
    r.last   = last;
    return r;
  endfunction

  function automatic void close_poll_fail(logic [2:0] code);
    fail_total++;
    rx_active = 1'b0;
    master_out_q.push_back(out_item(OUT_STATUS, 8'h00, 6'd0, 16'h0000, code,
                                    good_total, fail_total, 1'b1));
  endfunction

  function automatic void step_master(logic [1:0] kind, logic [7:0] addr, logic [7:0] b);
    logic [7:0]  req [8];
    logic [15:0] crc;
    logic [8:0]  pos;
    if (kind == KIND_START) begin
      req[0] = addr;
      req[1] = FUNC_CODE;
      req[2] = start_reg_m[15:8];
      req[3] = start_reg_m[7:0];
      req[4] = 8'(HOLD_REGS >> 8);
      req[5] = 8'(HOLD_REGS);
      crc = CRC_INIT;
      for (int k = 0; k < 6; k++) begin
        crc = crc16_byte(crc, req[k]);
      end
      req[6] = crc[7:0];
      req[7] = crc[15:8];
      for (int k = 0; k < 8; k++) begin
        master_out_q.push_back(out_item(OUT_TX, req[k], 6'd0, 16'h0000, ST_OK,
                                        32'd0, 32'd0, k == 7));
      end
      rx_active = 1'b1;
      poll_addr = addr;
      rx_count  = 9'd0;
      rx_crc    = CRC_INIT;
      rx_tail   = 16'h0000;
      addr_ok   = 1'b0;
      func_ok   = 1'b0;
      hi_hold   = 8'h00;
    end else if (!rx_active) begin
      // ignored outside a poll
    end else if (kind == KIND_BYTE) begin
      if (rx_count < FRAME_LIMIT) begin
        if (rx_count >= 9'd2) rx_crc = crc16_byte(rx_crc, rx_tail[7:0]);
        rx_tail = {b, rx_tail[15:8]};
        if (rx_count == 9'd0 && b == poll_addr) addr_ok = 1'b1;
        if (rx_count == 9'd1 && b == FUNC_CODE) func_ok = 1'b1;
        if (rx_count >= DATA_START && rx_count < DATA_END) begin
          pos = rx_count - DATA_START;
          if (!pos[0]) begin
            hi_hold = b;
          end else begin
            reg_img[pos[8:1] % HOLD_REGS] = {hi_hold, b};
          end
        end
        rx_count++;
      end
    end else if (kind == KIND_TIMEOUT) begin
      close_poll_fail(ST_TIMEOUT);
    end else if (rx_count < MIN_LEN) begin
      close_poll_fail(ST_SHORT);
    end else if (!addr_ok) begin
      close_poll_fail(ST_BAD_ADDR);
    end else if (!func_ok) begin
      close_poll_fail(ST_BAD_FUNC);
    end else if (rx_crc != rx_tail) begin
      close_poll_fail(ST_CRC_ERROR);
    end else begin
      good_total++;
      rx_active = 1'b0;
      for (int k = 0; k < HOLD_REGS; k++) begin
        master_out_q.push_back(out_item(OUT_REG, 8'h00, 6'(k), reg_img[k], ST_OK,
                                        32'd0, 32'd0, 1'b0));
      end
      master_out_q.push_back(out_item(OUT_STATUS, 8'h00, 6'd0, 16'h0000, ST_OK,
                                      good_total, fail_total, 1'b1));
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s differs, expected %0h got %0h", $realtime, what, want, got);
    end
  endtask

  // receiver stalls and result checking
  always @(posedge clk_i) begin : check_results
    master_out_t want;
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (master_out_q.size() == 0) begin
        report_mismatch("unexpected result transaction", 32'd0, {30'd0, out_kind_o});
      end else begin
        want = master_out_q.pop_front();
        if (out_kind_o !== want.kind) begin
          report_mismatch("out_kind", 32'(want.kind), 32'(out_kind_o));
        end
        if (tx_byte_o !== want.tx) report_mismatch("tx_byte", 32'(want.tx), 32'(tx_byte_o));
        if (reg_index_o !== want.idx) begin
          report_mismatch("reg_index", 32'(want.idx), 32'(reg_index_o));
        end
        if (reg_value_o !== want.value) begin
          report_mismatch("reg_value", 32'(want.value), 32'(reg_value_o));
        end
        if (status_code_o !== want.status) begin
          report_mismatch("status_code", 32'(want.status), 32'(status_code_o));
        end
        if (good_count_o !== want.good) report_mismatch("good_count", want.good, good_count_o);
        if (error_count_o !== want.errs) begin
          report_mismatch("error_count", want.errs, error_count_o);
        end
        if (last_o !== want.last) report_mismatch("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] addr, input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    slave_addr_i <= addr;
    rx_byte_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KIND_START || rx_active) items_fed++;
    step_master(kind, addr, b);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (master_out_q.size() != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_start_reg(input logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    start_reg_m = value;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_poll(input poll_mode_e mode);
    logic [7:0]  rsp [$];
    logic [7:0]  addr;
    logic [15:0] crc;
    int          cut;
    int          at;
    addr = pick_byte();
    send_item(KIND_START, addr, 8'($urandom));
    rsp.push_back(addr);
    rsp.push_back(FUNC_CODE);
    rsp.push_back(8'(2 * HOLD_REGS));
    for (int k = 0; k < 2 * HOLD_REGS; k++) begin
      rsp.push_back(pick_byte());
    end
    if (mode == PM_EXTRA) begin
      repeat ($urandom_range(1, 6)) rsp.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    foreach (rsp[k]) crc = crc16_byte(crc, rsp[k]);
    rsp.push_back(crc[7:0]);
    rsp.push_back(crc[15:8]);
    cut = rsp.size();
    case (mode)
      PM_BAD_ADDR: rsp[0] = rsp[0] ^ 8'($urandom_range(1, 255));
      PM_BAD_FUNC: rsp[1] = rsp[1] ^ 8'($urandom_range(1, 255));
      PM_BAD_CRC: begin
        at = $urandom_range(2, rsp.size() - 1);
        rsp[at] = rsp[at] ^ (8'd1 << $urandom_range(0, 7));
      end
      PM_SHORT: cut = $urandom_range(0, MIN_LEN - 1);
      PM_TIMEOUT, PM_RESTART: cut = $urandom_range(0, rsp.size());
      default: ;
    endcase
    for (int k = 0; k < cut; k++) begin
      send_item(KIND_BYTE, 8'($urandom), rsp[k]);
    end
    if (mode == PM_TIMEOUT) begin
      send_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom));
    end else if (mode != PM_RESTART) begin
      send_item(KIND_IDLE, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_ignored_while_idle();
    send_item(KIND_BYTE, 8'h00, 8'hFF);
    send_item(KIND_IDLE, 8'hFF, 8'h00);
    send_item(KIND_TIMEOUT, 8'hFF, 8'hFF);
  endtask

  task automatic test_request_extremes();
    write_start_reg(16'hFFFF);
    send_item(KIND_START, 8'hFF, 8'h00);
    send_item(KIND_TIMEOUT, 8'h00, 8'h00);
    send_item(KIND_START, 8'h00, 8'hFF);
    send_item(KIND_IDLE, 8'h00, 8'h00);
  endtask

  task automatic test_restart_mid_frame();
    send_item(KIND_START, 8'h5A, 8'hA5);
    send_item(KIND_BYTE, 8'hFF, 8'h5A);
    send_item(KIND_BYTE, 8'h00, FUNC_CODE);
    send_item(KIND_START, 8'hA5, 8'h5A);
    send_item(KIND_BYTE, 8'h00, 8'hFF);
    send_item(KIND_BYTE, 8'hFF, 8'h00);
    send_item(KIND_IDLE, 8'h00, 8'h00);
  endtask

  // well-formed response that runs past the frame limit
  task automatic test_overlong_frame();
    logic [7:0]  rsp [$];
    logic [7:0]  addr;
    logic [15:0] crc;
    addr = pick_byte();
    send_item(KIND_START, addr, 8'($urandom));
    rsp.push_back(addr);
    rsp.push_back(FUNC_CODE);
    while (rsp.size() < FRAME_MAX - 2) rsp.push_back(pick_byte());
    crc = CRC_INIT;
    foreach (rsp[k]) crc = crc16_byte(crc, rsp[k]);
    rsp.push_back(crc[7:0]);
    rsp.push_back(crc[15:8]);
    repeat (6) rsp.push_back(8'($urandom));
    foreach (rsp[k]) send_item(KIND_BYTE, 8'($urandom), rsp[k]);
    send_item(KIND_IDLE, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_poll_traffic(input int unsigned count);
    int unsigned target;
    int unsigned sel;
    target = items_fed + count;
    while (items_fed < target) begin
      if (!rx_active && $urandom_range(0, 15) == 0) write_start_reg(16'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 35) run_poll(PM_GOOD);
      else if (sel < 50) run_poll(PM_EXTRA);
      else if (sel < 58) run_poll(PM_BAD_ADDR);
      else if (sel < 66) run_poll(PM_BAD_FUNC);
      else if (sel < 76) run_poll(PM_BAD_CRC);
      else if (sel < 84) run_poll(PM_SHORT);
      else if (sel < 91) run_poll(PM_TIMEOUT);
      else if (sel < 96) run_poll(PM_RESTART);
      else send_item(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
    end
    if (rx_active) send_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    start_reg_m = 16'h0000;
    rx_active   = 1'b0;
    poll_addr   = 8'h00;
    rx_count    = 9'd0;
    rx_crc      = CRC_INIT;
    rx_tail     = 16'h0000;
    addr_ok     = 1'b0;
    func_ok     = 1'b0;
    hi_hold     = 8'h00;
    good_total  = 32'd0;
    fail_total  = 32'd0;
    foreach (reg_img[k]) reg_img[k] = 16'h0000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 7;
    recv_stall_pct = 52;
    test_ignored_while_idle();
    test_request_extremes();
    test_restart_mid_frame();
    test_poll_traffic(60);

    send_idle_pct  = 52;
    recv_stall_pct = 7;
    write_start_reg(16'h0000);
    test_poll_traffic(60);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_overlong_frame();
    test_poll_traffic(50);

    drain_results();
    if (mismatches == 0) begin
      $display("modbus_fc03_master_frame_engine: match");
    end else begin
      $display("modbus_fc03_master_frame_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("modbus_fc03_master_frame_engine: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/mbm_pkg.sv
hw/rtl/mbm_crc_serial.sv
hw/rtl/mbm_reg_store.sv
hw/rtl/modbus_fc03_master_frame_engine.sv
verif/testbench.sv
